// ===== design/smsa_pkg.sv =====
package smsa_pkg;

  localparam logic [31:0] SPV_MAGIC          = 32'h0723_0203;
  localparam logic [2:0]  HEADER_WORDS       = 3'd5;

  localparam logic [15:0] OP_MEMORY_MODEL    = 16'd14;
  localparam logic [15:0] OP_ENTRY_POINT     = 16'd15;
  localparam logic [15:0] OP_CAPABILITY      = 16'd17;
  localparam logic [15:0] OP_VARIABLE        = 16'd59;
  localparam logic [15:0] OP_DECORATE        = 16'd71;

  localparam logic [31:0] CAP_PSB_ADDRESSES  = 32'd5347;
  localparam logic [31:0] ADDR_PSB64         = 32'd5348;
  localparam logic [31:0] MEM_GLSL450        = 32'd1;
  localparam logic [31:0] EXEC_GL_COMPUTE    = 32'd5;
  localparam logic [31:0] SC_PUSH_CONSTANT   = 32'd9;
  localparam logic [31:0] SC_UNIFORM_CONST   = 32'd0;
  localparam logic [31:0] SC_UNIFORM         = 32'd2;
  localparam logic [31:0] SC_IMAGE           = 32'd10;
  localparam logic [31:0] SC_STORAGE_BUFFER  = 32'd12;
  localparam logic [31:0] SC_ATOMIC_COUNTER  = 32'd11;
  localparam logic [31:0] DEC_BINDING        = 32'd33;
  localparam logic [31:0] DEC_DESCRIPTOR_SET = 32'd34;

  localparam logic [2:0]  ERR_NONE              = 3'd0;
  localparam logic [2:0]  ERR_NOT_SPIRV         = 3'd1;
  localparam logic [2:0]  ERR_OVERRUN           = 3'd2;
  localparam logic [2:0]  ERR_TRUNCATED         = 3'd3;
  localparam logic [2:0]  ERR_NAME_UNTERMINATED = 3'd4;
  localparam logic [2:0]  ERR_NAME_STORAGE      = 3'd5;

  localparam int COUNTER_WIDTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH           = 4;
  localparam int QPTR_W                = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W                = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_MEMORY_MODEL,
    CLS_CAPABILITY,
    CLS_ENTRY,
    CLS_DECORATE,
    CLS_VARIABLE
  } class_t;

  // Word classified without regard to stream position.
  typedef struct packed {
    logic        last;
    logic [15:0] wc;
    class_t      op_class;
    logic        is_trunc;
    logic        is_magic;
    logic        is_psb64;
    logic        is_glsl450;
    logic        is_cap_psb;
    logic        is_binding;
    logic        is_push;
    logic        is_desc;
    logic        is_compute;
    logic [2:0]  lead_nz;
    logic        any_zero;
  } dec_t;

  typedef struct packed {
    logic valid;
    dec_t dec;
  } head_t;

endpackage

// ===== design/spirv_module_stream_analyzer_core.sv =====
// Channel  Direction  Handshake            Payload
// in       into core  in_valid / in_stall  word[31:0], last_word
// out      from core  out_valid / out_stall error_code[2:0], flags, counts, entry_name_bytes
//
// One word per cycle unless the queue is full or a final word is held on out_stall;
// the back end updates its registered parse state on each word it pops. The result
// register loads on the cycle the last word leaves the 4-entry queue slot it sat in.
// rst is synchronous and clears the queue, the parse state and out_valid.
// in_stall rises only when the queue is full; the back end keeps taking non-final
// words while a result waits on out_stall, and holds only a final word.
module spirv_module_stream_analyzer_core #(
  parameter int COUNTER_WIDTH = smsa_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] word,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  error_code,
  output logic        uses_psb64_glsl450,
  output logic        has_psb_capability,
  output logic        has_binding_decorations,
  output logic        has_descriptor_variables,
  output logic [15:0] compute_entry_count,
  output logic [31:0] entry_name_bytes,
  output logic [15:0] push_constant_count
);

  smsa_pkg::dec_t  dec;
  smsa_pkg::head_t head;
  logic            pop;
  logic            full;

  assign in_stall = full;

  smsa_front u_front (
    .word      (word),
    .last_word (last_word),
    .dec       (dec)
  );

  smsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid),
    .push_dec (dec),
    .full     (full),
    .head     (head),
    .pop      (pop)
  );

  smsa_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk                      (clk),
    .rst                      (rst),
    .head                     (head),
    .pop                      (pop),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .error_code               (error_code),
    .uses_psb64_glsl450       (uses_psb64_glsl450),
    .has_psb_capability       (has_psb_capability),
    .has_binding_decorations  (has_binding_decorations),
    .has_descriptor_variables (has_descriptor_variables),
    .compute_entry_count      (compute_entry_count),
    .entry_name_bytes         (entry_name_bytes),
    .push_constant_count      (push_constant_count)
  );

endmodule

// ===== design/smsa_front.sv =====
module smsa_front (
  input  logic [31:0]     word,
  input  logic            last_word,
  output smsa_pkg::dec_t  dec
);

  logic [15:0]      wc;
  logic [15:0]      op;
  smsa_pkg::class_t op_class;
  logic             is_trunc;
  logic [2:0]       lead_nz;

  assign wc = word[31:16];
  assign op = word[15:0];

  always_comb begin
    priority if (op == smsa_pkg::OP_MEMORY_MODEL) op_class = smsa_pkg::CLS_MEMORY_MODEL;
    else if (op == smsa_pkg::OP_CAPABILITY) op_class = smsa_pkg::CLS_CAPABILITY;
    else if (op == smsa_pkg::OP_ENTRY_POINT) op_class = smsa_pkg::CLS_ENTRY;
    else if (op == smsa_pkg::OP_DECORATE) op_class = smsa_pkg::CLS_DECORATE;
    else if (op == smsa_pkg::OP_VARIABLE) op_class = smsa_pkg::CLS_VARIABLE;
    else op_class = smsa_pkg::CLS_OTHER;
  end

  // Minimum word counts per opcode class; a Capability must be exactly two words.
  always_comb begin
    unique case (op_class)
      smsa_pkg::CLS_MEMORY_MODEL: is_trunc = (wc < 16'd3);
      smsa_pkg::CLS_CAPABILITY:   is_trunc = (wc != 16'd2);
      smsa_pkg::CLS_ENTRY:        is_trunc = (wc < 16'd4);
      smsa_pkg::CLS_DECORATE:     is_trunc = (wc < 16'd3);
      smsa_pkg::CLS_VARIABLE:     is_trunc = (wc < 16'd4);
      default:                    is_trunc = 1'b0;
    endcase
  end

  // Count nonzero bytes ahead of the first zero byte, low byte first.
  always_comb begin
    priority if (word[7:0] == 8'd0) lead_nz = 3'd0;
    else if (word[15:8] == 8'd0) lead_nz = 3'd1;
    else if (word[23:16] == 8'd0) lead_nz = 3'd2;
    else if (word[31:24] == 8'd0) lead_nz = 3'd3;
    else lead_nz = 3'd4;
  end

  assign dec.lead_nz    = lead_nz;
  assign dec.any_zero   = (word[7:0] == 8'd0) || (word[15:8] == 8'd0) ||
                          (word[23:16] == 8'd0) || (word[31:24] == 8'd0);
  assign dec.last       = last_word;
  assign dec.wc         = wc;
  assign dec.op_class   = op_class;
  assign dec.is_trunc   = is_trunc;
  assign dec.is_magic   = (word == smsa_pkg::SPV_MAGIC);
  assign dec.is_psb64   = (word == smsa_pkg::ADDR_PSB64);
  assign dec.is_glsl450 = (word == smsa_pkg::MEM_GLSL450);
  assign dec.is_cap_psb = (word == smsa_pkg::CAP_PSB_ADDRESSES);
  assign dec.is_binding = (word == smsa_pkg::DEC_BINDING) ||
                          (word == smsa_pkg::DEC_DESCRIPTOR_SET);
  assign dec.is_push    = (word == smsa_pkg::SC_PUSH_CONSTANT);
  assign dec.is_desc    = (word == smsa_pkg::SC_UNIFORM_CONST) ||
                          (word == smsa_pkg::SC_UNIFORM) ||
                          (word == smsa_pkg::SC_IMAGE) ||
                          (word == smsa_pkg::SC_ATOMIC_COUNTER) ||
                          (word == smsa_pkg::SC_STORAGE_BUFFER);
  assign dec.is_compute = (word == smsa_pkg::EXEC_GL_COMPUTE);

endmodule

// ===== design/smsa_queue.sv =====
module smsa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smsa_pkg::dec_t  push_dec,
  output logic            full,
  output smsa_pkg::head_t head,
  input  logic            pop
);

  localparam logic [smsa_pkg::QPTR_W-1:0] LAST_SLOT = smsa_pkg::QPTR_W'(smsa_pkg::QUEUE_DEPTH - 1);
  localparam logic [smsa_pkg::QCNT_W-1:0] FULL_CNT  = smsa_pkg::QCNT_W'(smsa_pkg::QUEUE_DEPTH);

  smsa_pkg::dec_t                slots [smsa_pkg::QUEUE_DEPTH];
  logic [smsa_pkg::QPTR_W-1:0]   wr_ptr;
  logic [smsa_pkg::QPTR_W-1:0]   rd_ptr;
  logic [smsa_pkg::QCNT_W-1:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign full       = (count == FULL_CNT);
  assign head.valid = (count != '0);
  assign head.dec   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/smsa_back.sv =====
module smsa_back #(
  parameter int COUNTER_WIDTH = smsa_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  smsa_pkg::head_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      error_code,
  output logic            uses_psb64_glsl450,
  output logic            has_psb_capability,
  output logic            has_binding_decorations,
  output logic            has_descriptor_variables,
  output logic [15:0]     compute_entry_count,
  output logic [31:0]     entry_name_bytes,
  output logic [15:0]     push_constant_count
);

  localparam int CNT_W = (COUNTER_WIDTH >= 16) ? 16 : COUNTER_WIDTH;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  smsa_pkg::dec_t   d;

  logic [2:0]       header_pos, header_pos_next;
  logic [15:0]      words_left, words_left_next;
  logic [15:0]      instr_len, instr_len_next;
  smsa_pkg::class_t instr_class, instr_class_next;
  logic             fop_psb64, fop_psb64_next;
  logic             pending_trunc, pending_trunc_next;
  logic [2:0]       sticky_error, sticky_error_next;
  logic [17:0]      name_len, name_len_next;
  logic             name_terminated, name_terminated_next;
  logic [3:0]       result_flags, result_flags_next;
  logic [CNT_W-1:0] entry_counter, entry_counter_next;
  logic [31:0]      storage_total, storage_total_next;
  logic [CNT_W-1:0] push_counter, push_counter_next;

  logic [15:0]      idx;
  logic [17:0]      scan_len;
  logic             scan_term;
  logic [32:0]      total_sum;
  logic [2:0]       final_error;
  logic             take_last;

  assign d         = head.dec;
  assign pop       = head.valid && (!d.last || !out_valid || !out_stall);
  assign take_last = pop && d.last;

  assign idx       = instr_len - words_left;
  assign scan_len  = name_len + (name_terminated ? 18'd0 : 18'(d.lead_nz));
  assign scan_term = name_terminated | d.any_zero;
  assign total_sum = {1'b0, storage_total} + 33'(scan_len) + 33'd1;

  always_comb begin
    header_pos_next      = header_pos;
    words_left_next      = words_left;
    instr_len_next       = instr_len;
    instr_class_next     = instr_class;
    fop_psb64_next       = fop_psb64;
    pending_trunc_next   = pending_trunc;
    sticky_error_next    = sticky_error;
    name_len_next        = name_len;
    name_terminated_next = name_terminated;
    result_flags_next    = result_flags;
    entry_counter_next   = entry_counter;
    storage_total_next   = storage_total;
    push_counter_next    = push_counter;

    if (sticky_error == smsa_pkg::ERR_NONE) begin
      if (header_pos < smsa_pkg::HEADER_WORDS) begin
        if (header_pos == 3'd0 && !d.is_magic) begin
          sticky_error_next = smsa_pkg::ERR_NOT_SPIRV;
        end
        header_pos_next = header_pos + 3'd1;
      end else if (words_left == 16'd0) begin
        // Instruction head word.
        if (d.wc == 16'd0) begin
          sticky_error_next = smsa_pkg::ERR_OVERRUN;
        end else begin
          instr_len_next       = d.wc;
          words_left_next      = d.wc - 16'd1;
          pending_trunc_next   = d.is_trunc;
          name_len_next        = '0;
          name_terminated_next = 1'b0;
          fop_psb64_next       = 1'b0;
          instr_class_next     = d.is_trunc ? smsa_pkg::CLS_OTHER : d.op_class;
          if (d.wc == 16'd1) begin
            if (d.is_trunc) begin
              sticky_error_next = smsa_pkg::ERR_TRUNCATED;
            end
            instr_class_next = smsa_pkg::CLS_OTHER;
          end
        end
      end else begin
        // Operand word.
        words_left_next = words_left - 16'd1;
        unique case (instr_class)
          smsa_pkg::CLS_MEMORY_MODEL: begin
            if (idx == 16'd1) begin
              fop_psb64_next = d.is_psb64;
            end else if (idx == 16'd2) begin
              result_flags_next[0] = fop_psb64 && d.is_glsl450;
            end
          end
          smsa_pkg::CLS_CAPABILITY: begin
            if (idx == 16'd1 && d.is_cap_psb) begin
              result_flags_next[1] = 1'b1;
            end
          end
          smsa_pkg::CLS_DECORATE: begin
            if (idx == 16'd2 && d.is_binding) begin
              result_flags_next[2] = 1'b1;
            end
          end
          smsa_pkg::CLS_VARIABLE: begin
            if (idx == 16'd3) begin
              if (d.is_push && push_counter != CNT_MAX) begin
                push_counter_next = push_counter + 1'b1;
              end
              if (d.is_desc) begin
                result_flags_next[3] = 1'b1;
              end
            end
          end
          smsa_pkg::CLS_ENTRY: begin
            if (idx == 16'd1 && !d.is_compute) begin
              instr_class_next = smsa_pkg::CLS_OTHER;
            end else if (idx >= 16'd3) begin
              name_len_next        = scan_len;
              name_terminated_next = scan_term;
            end
          end
          default: begin
          end
        endcase

        // Close the instruction on its final word.
        if (words_left == 16'd1) begin
          if (instr_class_next == smsa_pkg::CLS_ENTRY) begin
            if (!name_terminated_next) begin
              sticky_error_next = smsa_pkg::ERR_NAME_UNTERMINATED;
            end else if (total_sum[32]) begin
              sticky_error_next = smsa_pkg::ERR_NAME_STORAGE;
            end else begin
              storage_total_next = total_sum[31:0];
              if (entry_counter != CNT_MAX) begin
                entry_counter_next = entry_counter + 1'b1;
              end
            end
          end else if (pending_trunc) begin
            sticky_error_next = smsa_pkg::ERR_TRUNCATED;
          end
          instr_class_next = smsa_pkg::CLS_OTHER;
        end
      end
    end
  end

  always_comb begin
    final_error = sticky_error_next;
    if (sticky_error_next == smsa_pkg::ERR_NONE) begin
      if (header_pos_next < smsa_pkg::HEADER_WORDS) begin
        final_error = smsa_pkg::ERR_NOT_SPIRV;
      end else if (words_left_next != 16'd0) begin
        final_error = smsa_pkg::ERR_OVERRUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || take_last) begin
      header_pos      <= '0;
      words_left      <= '0;
      instr_len       <= '0;
      instr_class     <= smsa_pkg::CLS_OTHER;
      fop_psb64       <= 1'b0;
      pending_trunc   <= 1'b0;
      sticky_error    <= smsa_pkg::ERR_NONE;
      name_len        <= '0;
      name_terminated <= 1'b0;
      result_flags    <= '0;
      entry_counter   <= '0;
      storage_total   <= '0;
      push_counter    <= '0;
    end else if (pop) begin
      header_pos      <= header_pos_next;
      words_left      <= words_left_next;
      instr_len       <= instr_len_next;
      instr_class     <= instr_class_next;
      fop_psb64       <= fop_psb64_next;
      pending_trunc   <= pending_trunc_next;
      sticky_error    <= sticky_error_next;
      name_len        <= name_len_next;
      name_terminated <= name_terminated_next;
      result_flags    <= result_flags_next;
      entry_counter   <= entry_counter_next;
      storage_total   <= storage_total_next;
      push_counter    <= push_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result; all payload fields read zero on error.
  always_ff @(posedge clk) begin
    if (take_last) begin
      error_code <= final_error;
      if (final_error == smsa_pkg::ERR_NONE) begin
        uses_psb64_glsl450       <= result_flags_next[0];
        has_psb_capability       <= result_flags_next[1];
        has_binding_decorations  <= result_flags_next[2];
        has_descriptor_variables <= result_flags_next[3];
        compute_entry_count      <= 16'(entry_counter_next);
        entry_name_bytes         <= storage_total_next;
        push_constant_count      <= 16'(push_counter_next);
      end else begin
        uses_psb64_glsl450       <= 1'b0;
        has_psb_capability       <= 1'b0;
        has_binding_decorations  <= 1'b0;
        has_descriptor_variables <= 1'b0;
        compute_entry_count      <= '0;
        entry_name_bytes         <= '0;
        push_constant_count      <= '0;
      end
    end
  end

endmodule
